// ===== rtl/rbfa_pkg.sv =====
// shared constants, request codes and item structs of the frame allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rbfa_pkg;
  localparam int MAX_FRAMES = 65536;
  localparam int PAGE_SHIFT = 12;
  localparam int WORD_BITS  = 64;
  localparam int COUNT_BITS = 16;
  localparam int ADDR_W     = 40;
  localparam int RES_W      = 28;
  localparam int MAP_WORDS  = MAX_FRAMES / WORD_BITS;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int NUM_W      = FRAME_W + 1;
  localparam int BIT_W      = $clog2(WORD_BITS);

  localparam logic [COUNT_BITS-1:0] PIN_COUNT = '1;

  localparam logic [3:0] ACT_ALLOC_ONE   = 4'd0;
  localparam logic [3:0] ACT_ALLOC_RUN   = 4'd1;
  localparam logic [3:0] ACT_ALLOC_ABOVE = 4'd2;
  localparam logic [3:0] ACT_FREE_ONE    = 4'd3;
  localparam logic [3:0] ACT_FREE_RUN    = 4'd4;
  localparam logic [3:0] ACT_INC_REF     = 4'd5;
  localparam logic [3:0] ACT_QUERY       = 4'd6;
  localparam logic [3:0] ACT_RESERVE     = 4'd7;
  localparam logic [3:0] ACT_SEED_FREE   = 4'd8;

  localparam logic CFG_IDX_TRACKED = 1'b0;
  localparam logic CFG_IDX_ENABLED = 1'b1;

  typedef enum logic [2:0] {
    OP_NOP, OP_ALLOC_ONE, OP_ALLOC_RUN, OP_DROP, OP_INC_REF, OP_QUERY, OP_RESERVE, OP_SEED
  } op_t;

  typedef struct packed {
    logic [3:0]        action;
    logic [ADDR_W-1:0] address;
    logic [NUM_W-1:0]  frame_count;
    logic [ADDR_W-1:0] byte_length;
  } in_item_t;

  typedef struct packed {
    logic [RES_W-1:0]      result_address;
    logic [COUNT_BITS-1:0] ref_value;
    logic [NUM_W-1:0]      used_count;
    logic [NUM_W-1:0]      free_count;
    logic [NUM_W-1:0]      usable_count;
    logic [NUM_W-1:0]      used_usable_count;
  } out_item_t;

  typedef struct packed {
    op_t              op;
    logic [NUM_W-1:0] lo;
    logic [NUM_W-1:0] hi;
    logic [NUM_W-1:0] len;
  } cmd_t;
endpackage
`default_nettype wire

// ===== rtl/rbfa_front.sv =====
// request decoder: turns an accepted request into a frame range command
// depends on rbfa_pkg
`timescale 1ns / 1ps
`default_nettype none
module rbfa_front (
  input  rbfa_pkg::in_item_t        item,
  input  logic [rbfa_pkg::NUM_W-1:0] live_n,
  input  logic                      enabled,
  output rbfa_pkg::cmd_t            cmd
);
  import rbfa_pkg::*;

  localparam int FRM_W = ADDR_W - PAGE_SHIFT;
  localparam int SUM_W = ADDR_W + 2;
  localparam int END_W = SUM_W - PAGE_SHIFT;

  logic [FRM_W-1:0] frame;
  logic             in_rng;
  logic             nonzero;
  logic             cnt_nz;
  logic [NUM_W-1:0] lo;
  logic [NUM_W-1:0] lo_p1;
  logic [FRM_W:0]   run_sum;
  logic [NUM_W-1:0] run_hi;
  logic [SUM_W-1:0] res_sum;
  logic [END_W-1:0] res_end;
  logic [NUM_W-1:0] res_hi;

  assign frame   = item.address[ADDR_W-1:PAGE_SHIFT];
  assign in_rng  = frame < FRM_W'(live_n);
  assign nonzero = frame != '0;
  assign cnt_nz  = item.frame_count != '0;
  assign lo      = frame[NUM_W-1:0];
  assign lo_p1   = lo + NUM_W'(1);
  assign run_sum = (FRM_W+1)'(frame) + (FRM_W+1)'(item.frame_count);
  assign run_hi  = (run_sum > (FRM_W+1)'(live_n)) ? live_n : run_sum[NUM_W-1:0];
  assign res_sum = SUM_W'(item.address) + SUM_W'(item.byte_length)
                 + SUM_W'((1 << PAGE_SHIFT) - 1);
  assign res_end = res_sum[SUM_W-1:PAGE_SHIFT];
  assign res_hi  = (res_end > END_W'(live_n)) ? live_n : res_end[NUM_W-1:0];

  always_comb begin
    cmd.op  = OP_NOP;
    cmd.lo  = '0;
    cmd.hi  = '0;
    cmd.len = item.frame_count;
    unique case (item.action)
      ACT_ALLOC_ONE: begin
        if (enabled) cmd.op = OP_ALLOC_ONE;
      end
      ACT_ALLOC_RUN: begin
        if (enabled && cnt_nz) begin
          cmd.op = OP_ALLOC_RUN;
          cmd.lo = NUM_W'(1);
        end
      end
      ACT_ALLOC_ABOVE: begin
        if (enabled && cnt_nz && in_rng) begin
          cmd.op = OP_ALLOC_RUN;
          cmd.lo = nonzero ? lo : NUM_W'(1);
        end
      end
      ACT_FREE_ONE: begin
        if (enabled && nonzero && in_rng) begin
          cmd.op = OP_DROP;
          cmd.lo = lo;
          cmd.hi = lo_p1;
        end
      end
      ACT_FREE_RUN: begin
        if (enabled && cnt_nz && in_rng) begin
          cmd.op = OP_DROP;
          cmd.lo = lo;
          cmd.hi = run_hi;
        end
      end
      ACT_INC_REF: begin
        if (enabled && nonzero && in_rng) begin
          cmd.op = OP_INC_REF;
          cmd.lo = lo;
          cmd.hi = lo_p1;
        end
      end
      ACT_QUERY: begin
        if (enabled && in_rng) begin
          cmd.op = OP_QUERY;
          cmd.lo = lo;
          cmd.hi = lo_p1;
        end
      end
      ACT_RESERVE: begin
        if (enabled && item.byte_length != '0 && in_rng) begin
          cmd.op = OP_RESERVE;
          cmd.lo = lo;
          cmd.hi = res_hi;
        end
      end
      ACT_SEED_FREE: begin
        if (in_rng) begin
          cmd.op = OP_SEED;
          cmd.lo = lo;
          cmd.hi = run_hi;
        end
      end
      default: cmd.op = OP_NOP;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/rbfa_cmdq.sv =====
// two-entry command queue between decoder and engine
// depends on rbfa_pkg
`timescale 1ns / 1ps
`default_nettype none
module rbfa_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  rbfa_pkg::cmd_t wr_cmd,
  output logic           full,
  output logic           valid,
  input  logic           rd_en,
  output rbfa_pkg::cmd_t rd_cmd
);
  import rbfa_pkg::*;

  cmd_t       ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full   = cnt_r == 2'd2;
  assign valid  = cnt_r != 2'd0;
  assign rd_cmd = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) ent_r[wp_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rbfa_back.sv =====
// allocation engine: used bitmap, share count memory, frame walk and result register
// depends on rbfa_pkg
`timescale 1ns / 1ps
`default_nettype none
module rbfa_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rbfa_pkg::NUM_W-1:0] live_n,
  input  logic                       cmd_valid,
  input  rbfa_pkg::cmd_t             cmd,
  output logic                       cmd_pop,
  output logic                       clearing,
  output logic                       res_valid,
  input  logic                       res_pop,
  output rbfa_pkg::out_item_t        res_item
);
  import rbfa_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_EVAL  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic                  phase_r, phase_nxt;
  logic                  retry_r, retry_nxt;
  logic [NUM_W-1:0]      f_r, f_nxt;
  logic [NUM_W-1:0]      hi_r, hi_nxt;
  logic [NUM_W-1:0]      len_r, len_nxt;
  logic [NUM_W-1:0]      run_r, run_nxt;
  logic [FRAME_W-1:0]    start_r, start_nxt;
  logic [FRAME_W-1:0]    cursor_r, cursor_nxt;
  logic [NUM_W-1:0]      used_r, used_nxt;
  logic [NUM_W-1:0]      usable_r, usable_nxt;
  logic [RES_W-1:0]      addr_r, addr_nxt;
  logic [COUNT_BITS-1:0] refv_r, refv_nxt;
  logic                  res_v_r;
  out_item_t             out_r;

  logic [WORD_BITS-1:0]  map_mem [MAP_WORDS];
  logic [COUNT_BITS-1:0] cnt_mem [MAX_FRAMES];
  logic [WORD_BITS-1:0]  map_q, map_wd;
  logic [COUNT_BITS-1:0] cnt_q, cnt_wd;
  logic                  map_we, cnt_we;

  logic                  scanning;
  logic [NUM_W-1:0]      limit;
  logic                  cur_bit;
  logic [WORD_BITS-1:0]  bit_mask;
  logic [NUM_W-1:0]      f_inc;
  logic [NUM_W-1:0]      run_inc;
  logic [FRAME_W-1:0]    start_n;
  logic                  load;
  logic                  pop_ok;
  logic [NUM_W-1:0]      freec;
  logic [NUM_W-1:0]      uu;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[f_r[FRAME_W-1:BIT_W]] <= map_wd;
    map_q <= map_mem[f_r[FRAME_W-1:BIT_W]];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[f_r[FRAME_W-1:0]] <= cnt_wd;
    cnt_q <= cnt_mem[f_r[FRAME_W-1:0]];
  end

  assign scanning = (op_r == OP_ALLOC_ONE || op_r == OP_ALLOC_RUN) && !phase_r;
  assign limit    = scanning ? live_n : hi_r;
  assign cur_bit  = map_q[f_r[BIT_W-1:0]];
  assign bit_mask = WORD_BITS'(1) << f_r[BIT_W-1:0];
  assign f_inc    = f_r + NUM_W'(1);
  assign run_inc  = run_r + NUM_W'(1);
  assign start_n  = (run_r == '0) ? f_r[FRAME_W-1:0] : start_r;
  assign pop_ok   = res_pop && res_v_r;
  assign freec    = (live_n > used_r) ? live_n - used_r : '0;
  assign uu       = (usable_r > freec) ? usable_r - freec : '0;

  assign clearing  = state_r == ST_CLEAR;
  assign res_valid = res_v_r;
  assign res_item  = out_r;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    phase_nxt  = phase_r;
    retry_nxt  = retry_r;
    f_nxt      = f_r;
    hi_nxt     = hi_r;
    len_nxt    = len_r;
    run_nxt    = run_r;
    start_nxt  = start_r;
    cursor_nxt = cursor_r;
    used_nxt   = used_r;
    usable_nxt = usable_r;
    addr_nxt   = addr_r;
    refv_nxt   = refv_r;
    map_we     = 1'b0;
    cnt_we     = 1'b0;
    map_wd     = map_q;
    cnt_wd     = cnt_q;
    cmd_pop    = 1'b0;
    load       = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        map_we = 1'b1;
        map_wd = '1;
        cnt_we = 1'b1;
        cnt_wd = COUNT_BITS'(1);
        f_nxt  = f_inc;
        if (f_r[FRAME_W-1:0] == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          op_nxt    = cmd.op;
          f_nxt     = (cmd.op == OP_ALLOC_ONE) ? NUM_W'(cursor_r) : cmd.lo;
          hi_nxt    = cmd.hi;
          len_nxt   = cmd.len;
          phase_nxt = 1'b0;
          retry_nxt = 1'b0;
          run_nxt   = '0;
          addr_nxt  = '0;
          refv_nxt  = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (f_r >= limit) begin
          if (scanning && op_r == OP_ALLOC_ONE && !retry_r && cursor_r > FRAME_W'(1)) begin
            retry_nxt = 1'b1;
            f_nxt     = NUM_W'(1);
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_READ;
        f_nxt     = f_inc;
        if (phase_r) begin
          map_we   = 1'b1;
          map_wd   = map_q | bit_mask;
          cnt_we   = 1'b1;
          cnt_wd   = COUNT_BITS'(1);
          used_nxt = used_r + NUM_W'(1);
        end else begin
          unique case (op_r)
            OP_ALLOC_ONE: begin
              if (!cur_bit) begin
                phase_nxt  = 1'b1;
                f_nxt      = f_r;
                hi_nxt     = f_inc;
                addr_nxt   = {f_r[FRAME_W-1:0], PAGE_SHIFT'(0)};
                cursor_nxt = (f_inc >= live_n) ? FRAME_W'(1) : f_inc[FRAME_W-1:0];
              end
            end
            OP_ALLOC_RUN: begin
              if (!cur_bit) begin
                if (run_inc == len_r) begin
                  phase_nxt = 1'b1;
                  f_nxt     = NUM_W'(start_n);
                  hi_nxt    = NUM_W'(start_n) + len_r;
                  addr_nxt  = {start_n, PAGE_SHIFT'(0)};
                end else begin
                  run_nxt   = run_inc;
                  start_nxt = start_n;
                end
              end else begin
                run_nxt = '0;
              end
            end
            OP_DROP: begin
              if (cur_bit && cnt_q != PIN_COUNT) begin
                cnt_we = 1'b1;
                if (cnt_q > COUNT_BITS'(1)) begin
                  cnt_wd = cnt_q - COUNT_BITS'(1);
                end else begin
                  cnt_wd   = '0;
                  map_we   = 1'b1;
                  map_wd   = map_q & ~bit_mask;
                  used_nxt = used_r - NUM_W'(1);
                end
              end
            end
            OP_INC_REF: begin
              if (cur_bit && cnt_q != PIN_COUNT) begin
                cnt_we = 1'b1;
                cnt_wd = cnt_q + COUNT_BITS'(1);
              end
            end
            OP_QUERY: begin
              refv_nxt = cnt_q;
            end
            OP_RESERVE: begin
              if (!cur_bit) begin
                map_we   = 1'b1;
                map_wd   = map_q | bit_mask;
                cnt_we   = 1'b1;
                cnt_wd   = COUNT_BITS'(1);
                used_nxt = used_r + NUM_W'(1);
              end
            end
            OP_SEED: begin
              if (cur_bit) begin
                map_we   = 1'b1;
                map_wd   = map_q & ~bit_mask;
                cnt_we   = 1'b1;
                cnt_wd   = '0;
                used_nxt = used_r - NUM_W'(1);
                if (usable_r != '1) usable_nxt = usable_r + NUM_W'(1);
              end
            end
            default: state_nxt = ST_READ;
          endcase
        end
      end
      ST_DONE: begin
        if (!res_v_r || pop_ok) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      f_r      <= '0;
      cursor_r <= FRAME_W'(1);
      used_r   <= NUM_W'(MAX_FRAMES);
      usable_r <= '0;
      res_v_r  <= 1'b0;
      op_r     <= OP_NOP;
      phase_r  <= 1'b0;
      retry_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      f_r      <= f_nxt;
      cursor_r <= cursor_nxt;
      used_r   <= used_nxt;
      usable_r <= usable_nxt;
      op_r     <= op_nxt;
      phase_r  <= phase_nxt;
      retry_r  <= retry_nxt;
      if (load) res_v_r <= 1'b1;
      else if (pop_ok) res_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    hi_r    <= hi_nxt;
    len_r   <= len_nxt;
    run_r   <= run_nxt;
    start_r <= start_nxt;
    addr_r  <= addr_nxt;
    refv_r  <= refv_nxt;
    if (load) begin
      out_r.result_address    <= addr_r;
      out_r.ref_value         <= refv_r;
      out_r.used_count        <= used_r;
      out_r.free_count        <= freec;
      out_r.usable_count      <= usable_r;
      out_r.used_usable_count <= uu;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= NUM_W'(MAX_FRAMES))
    else $error("used total above frame count");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    (map_we || cnt_we) |-> (state_r == ST_EVAL || state_r == ST_CLEAR))
    else $error("memory write outside frame step");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == ST_IDLE && cmd_valid))
    else $error("command taken while busy");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !res_v_r) |=> (res_v_r && state_r == ST_IDLE))
    else $error("result not loaded");
endmodule
`default_nettype wire

// ===== rtl/refcounted_bitmap_frame_allocator.sv =====
// page frame allocator top: config registers, decoder, command queue, engine
// depends on rbfa_pkg, rbfa_front, rbfa_cmdq, rbfa_back
//
// requests enter through push/full and leave through empty/pop, one result per
// request, in order. a request is decoded on entry and parked in a two-entry
// queue, so two queued requests, one finished request and one waiting result
// can be held while the receiver stalls; the engine stops only when its result
// register is occupied.
// the engine visits each frame in ST_READ, then ST_EVAL (bitmap word and share
// count are read from single-port memories, then written back). a scan visits
// frames until a fit is found (up to the tracked count, twice for a wrapping
// single-frame allocation), a range request visits each frame of its clipped
// range, and an allocation then walks its run again to mark it. after reset a
// clearing pass sets every bitmap word to all ones and every share count to 1;
// full stays high during it, while configuration writes are taken as usual.
// tracked_frames lies at byte address 0 and enabled at 4; writes are meant for
// idle periods only.
`timescale 1ns / 1ps
`default_nettype none
module refcounted_bitmap_frame_allocator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  rbfa_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output rbfa_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rbfa_pkg::*;

  logic [NUM_W-1:0] tracked_r;
  logic             enabled_r;
  logic [NUM_W-1:0] live_n;
  logic             cfg_wr;
  cmd_t             dec_cmd;
  cmd_t             q_cmd;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic             clearing;
  logic             res_valid;
  logic             accept;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == CFG_IDX_ENABLED) ? {31'b0, enabled_r}
                                                : {{(32-NUM_W){1'b0}}, tracked_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracked_r <= NUM_W'(MAX_FRAMES);
      enabled_r <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == CFG_IDX_ENABLED) enabled_r <= pwdata[0];
      else tracked_r <= pwdata[NUM_W-1:0];
    end
  end

  assign live_n = (tracked_r > NUM_W'(MAX_FRAMES)) ? NUM_W'(MAX_FRAMES) : tracked_r;
  assign full   = q_full || clearing;
  assign accept = push && !full;
  assign empty  = !res_valid;

  rbfa_front u_front (
    .item    (in_item),
    .live_n  (live_n),
    .enabled (enabled_r),
    .cmd     (dec_cmd)
  );

  rbfa_cmdq u_cmdq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (accept),
    .wr_cmd (dec_cmd),
    .full   (q_full),
    .valid  (q_valid),
    .rd_en  (q_pop),
    .rd_cmd (q_cmd)
  );

  rbfa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .live_n    (live_n),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .clearing  (clearing),
    .res_valid (res_valid),
    .res_pop   (pop),
    .res_item  (out_item)
  );
endmodule
`default_nettype wire
